### rtl/convex_hull_vertex_offset_defines.svh
// Assertion macros used by the vertex offset controller.
`ifndef CONVEX_HULL_VERTEX_OFFSET_DEFINES_SVH
`define CONVEX_HULL_VERTEX_OFFSET_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CHVO_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CHVO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHVO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/chvo_pkg.sv
// Shared types and constants of the vertex offset block.
`default_nettype none
package chvo_pkg;
    localparam int MAX_PLANES_DEF = 16;
    localparam int NW    = 16;
    localparam int DW    = 32;
    localparam int XW    = 31;
    localparam int TOLW  = 29;
    localparam int NUMW  = 64;
    localparam int DETW  = 48;
    localparam int PLW   = 3 * NW + DW;

    localparam logic [DW-1:0]   SHIFT_RESET = '0;
    localparam logic [TOLW-1:0] TOL_RESET   = 29'd2684355;

    localparam logic REG_SHIFT = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    typedef enum logic [1:0] {
        XS_1I,
        XS_J1,
        XS_IJ
    } xsel_t;

    typedef struct packed {
        logic       wr_plane;
        logic       ld_p1;
        logic       ld_pi;
        logic       ld_pj;
        xsel_t      xsel;
        logic       xmul;
        logic       xsub;
        logic       sq;
        logic       cmp;
        logic       tmul;
        logic       tsum;
        logic       nmul;
        logic       nsum;
        logic [1:0] k;
        logic       div_start;
        logic       coord_ld;
        logic       out_ld;
        logic       found;
    } chvo_cmd_t;

    typedef struct packed {
        logic par;
        logic det_zero;
        logic div_done;
    } chvo_sts_t;
endpackage
`default_nettype wire

### rtl/convex_hull_vertex_offset.sv
// Loading: one plane per transaction; the last plane starts the pair search.
// Each plane or pair is crossed, squared and compared; pairs add a triple product.
// The result follows after three divisions on one shared divider.
// Throughput: one plane per cycle while loading; one vertex at a time during the search.
// Reset (aresetn, synchronous, active low) clears the plane count and restores registers.
`default_nettype none
module convex_hull_vertex_offset import chvo_pkg::*; #(
    parameter int MAX_PLANES_PER_VERTEX = MAX_PLANES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic           cfg_addr,
    input  wire logic [DW-1:0]  cfg_wdata,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // normal_x, normal_y, normal_z, plane_offset
    input  wire logic [PLW-1:0] s_tdata,
    input  wire logic           s_tlast,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // point_x, point_y, point_z
    output logic [3*DW-1:0]     m_tdata,
    // point_found, saturated
    output logic [1:0]          m_tuser
);
    chvo_cmd_t cmd;
    chvo_sts_t sts;
    logic [$clog2(MAX_PLANES_PER_VERTEX)-1:0] waddr, raddr;

    chvo_ctrl #(
        .MAX_PLANES (MAX_PLANES_PER_VERTEX)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .waddr    (waddr),
        .raddr    (raddr)
    );

    chvo_datapath #(
        .MAX_PLANES (MAX_PLANES_PER_VERTEX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .waddr     (waddr),
        .raddr     (raddr),
        .sts       (sts),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );
endmodule
`default_nettype wire

### rtl/chvo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chvo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/chvo_div.sv
// Restoring divider that turns numerator and determinant into a saturated Q16.16 coordinate.
`default_nettype none
module chvo_div import chvo_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic signed [NUMW-1:0] num,
    input  wire logic signed [DETW-1:0] det,
    output logic                        done,
    output logic signed [DW-1:0]        coord,
    output logic                        sat
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    localparam int QW = 33;

    dstate_t         state_reg, state_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [DETW-1:0] rem_reg, rem_next;
    logic [DETW-1:0] dmag_reg, dmag_next;
    logic [QW-1:0]   sh_reg, sh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next;
    logic [DW-1:0]   coord_reg, coord_next;
    logic            sat_reg, sat_next;

    logic [NUMW-1:0] nmag;
    logic [DETW-1:0] dmag;
    logic            ov;
    logic [DETW:0]   trial;
    logic            ge;

    always_comb begin
        nmag  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        dmag  = det[DETW-1] ? DETW'(-det) : DETW'(det);
        ov    = {3'b000, nmag} >= {dmag, 19'd0};
        trial = {rem_reg, sh_reg[QW-1]};
        ge    = trial >= {1'b0, dmag_reg};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        coord_next = coord_reg;
        sat_next   = sat_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    neg_next  = (num[NUMW-1] == det[DETW-1]);
                    dmag_next = dmag;
                    rem_next  = DETW'(nmag >> 19);
                    sh_next   = {nmag[18:0], 14'd0};
                    q_next    = '0;
                    cnt_next  = '0;
                    if (ov) begin
                        q_next     = {1'b1, 32'd0};
                        state_next = D_FIN;
                    end else begin
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN: begin
                rem_next = ge ? DETW'(trial - {1'b0, dmag_reg}) : trial[DETW-1:0];
                q_next   = {q_reg[QW-2:0], ge};
                sh_next  = {sh_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 1)) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                done_next  = 1'b1;
                state_next = D_IDLE;
                if (neg_reg) begin
                    if (q_reg > {2'b01, 31'd0}) begin
                        coord_next = {1'b1, 31'd0};
                        sat_next   = 1'b1;
                    end else begin
                        coord_next = DW'(-q_reg);
                        sat_next   = 1'b0;
                    end
                end else if (q_reg > {2'b00, {31{1'b1}}}) begin
                    coord_next = {1'b0, {31{1'b1}}};
                    sat_next   = 1'b1;
                end else begin
                    coord_next = q_reg[DW-1:0];
                    sat_next   = 1'b0;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dmag_reg  <= dmag_next;
        sh_reg    <= sh_next;
        q_reg     <= q_next;
        neg_reg   <= neg_next;
        coord_reg <= coord_next;
        sat_reg   <= sat_next;
    end

    assign done  = done_reg;
    assign coord = coord_reg;
    assign sat   = sat_reg;
endmodule
`default_nettype wire

### rtl/chvo_datapath.sv
// Datapath: plane store, configuration, cross and triple products, numerators and divider.
`default_nettype none
module chvo_datapath import chvo_pkg::*; #(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [DW-1:0]                 cfg_wdata,
    input  wire logic [PLW-1:0]                in_data,
    input  wire chvo_cmd_t                     cmd,
    input  wire logic [$clog2(MAX_PLANES)-1:0] waddr,
    input  wire logic [$clog2(MAX_PLANES)-1:0] raddr,
    output chvo_sts_t                          sts,
    output logic [3*DW-1:0]                    out_data,
    output logic [1:0]                         out_user
);
    logic signed [DW-1:0]   shift_reg;
    logic [TOLW-1:0]        tol_reg;

    logic signed [NW-1:0]   wn [3];
    logic signed [DW:0]     dsub;
    logic signed [DW-1:0]   wd;
    logic [PLW-1:0]         wdata, rdata;

    logic signed [NW-1:0]   n1_reg [3], ni_reg [3], nj_reg [3];
    logic signed [DW-1:0]   d1_reg, di_reg, dj_reg;
    logic signed [NW-1:0]   xa [3], xb [3];
    logic signed [2*NW-1:0] prod_reg [6];
    logic signed [XW-1:0]   xres [3];
    logic signed [XW-1:0]   xres_reg [3], c12_reg [3], c31_reg [3], c23_reg [3];
    logic signed [61:0]     sqf [3];
    logic [59:0]            sq_reg [3];
    logic                   par_reg;
    logic signed [NW+XW-1:0] tp_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic signed [DW+XW-1:0] nm_reg [3];
    logic signed [NUMW-1:0] num_reg;
    logic signed [DW-1:0]   coord_reg [3];
    logic                   sat_reg;
    logic signed [DW-1:0]   dcoord;
    logic                   ddone, dsat;
    logic [DW-1:0]          ox, oy, oz;
    logic [3*DW-1:0]        out_data_reg;
    logic [1:0]             out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
            tol_reg   <= TOL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SHIFT: shift_reg <= cfg_wdata;
                REG_TOL:   tol_reg   <= cfg_wdata[TOLW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wn[k] = in_data[k*NW +: NW];
            if (wn[k] > 16'sd16384) begin
                wn[k] = 16'sd16384;
            end else if (wn[k] < -16'sd16384) begin
                wn[k] = -16'sd16384;
            end
        end
        dsub = (DW+1)'($signed(in_data[3*NW +: DW])) - (DW+1)'(shift_reg);
        if (dsub > (DW+1)'(33'sh0_7FFF_FFFF)) begin
            wd = {1'b0, {(DW-1){1'b1}}};
        end else if (dsub < -(DW+1)'(33'sh0_8000_0000)) begin
            wd = {1'b1, {(DW-1){1'b0}}};
        end else begin
            wd = dsub[DW-1:0];
        end
        wdata = {wd, wn[2], wn[1], wn[0]};
    end

    chvo_ram #(
        .WIDTH (PLW),
        .DEPTH (MAX_PLANES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_plane),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unique case (cmd.xsel)
                XS_J1: begin
                    xa[k] = nj_reg[k];
                    xb[k] = n1_reg[k];
                end
                XS_IJ: begin
                    xa[k] = ni_reg[k];
                    xb[k] = nj_reg[k];
                end
                default: begin
                    xa[k] = n1_reg[k];
                    xb[k] = ni_reg[k];
                end
            endcase
        end
        xres[0] = XW'(prod_reg[0] - prod_reg[1]);
        xres[1] = XW'(prod_reg[2] - prod_reg[3]);
        xres[2] = XW'(prod_reg[4] - prod_reg[5]);
        for (int k = 0; k < 3; k++) begin
            sqf[k] = xres_reg[k] * xres_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_p1) begin
            n1_reg <= wn;
            d1_reg <= wd;
        end
        if (cmd.ld_pi) begin
            for (int k = 0; k < 3; k++) begin
                ni_reg[k] <= rdata[k*NW +: NW];
            end
            di_reg <= rdata[3*NW +: DW];
        end
        if (cmd.ld_pj) begin
            for (int k = 0; k < 3; k++) begin
                nj_reg[k] <= rdata[k*NW +: NW];
            end
            dj_reg <= rdata[3*NW +: DW];
        end
        if (cmd.xmul) begin
            prod_reg[0] <= xa[1] * xb[2];
            prod_reg[1] <= xa[2] * xb[1];
            prod_reg[2] <= xa[2] * xb[0];
            prod_reg[3] <= xa[0] * xb[2];
            prod_reg[4] <= xa[0] * xb[1];
            prod_reg[5] <= xa[1] * xb[0];
        end
        if (cmd.xsub) begin
            xres_reg <= xres;
            case (cmd.xsel)
                XS_J1:   c31_reg <= xres;
                XS_IJ:   c23_reg <= xres;
                default: c12_reg <= xres;
            endcase
        end
        if (cmd.sq) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= sqf[k][59:0];
            end
        end
        if (cmd.cmp) begin
            par_reg <= (sq_reg[0] + sq_reg[1] + sq_reg[2]) < {3'b000, tol_reg, 28'd0};
        end
        if (cmd.tmul) begin
            for (int k = 0; k < 3; k++) begin
                tp_reg[k] <= n1_reg[k] * c23_reg[k];
            end
        end
        if (cmd.tsum) begin
            det_reg <= DETW'(tp_reg[0]) + DETW'(tp_reg[1]) + DETW'(tp_reg[2]);
        end
        if (cmd.nmul) begin
            nm_reg[0] <= d1_reg * c23_reg[cmd.k];
            nm_reg[1] <= di_reg * c31_reg[cmd.k];
            nm_reg[2] <= dj_reg * c12_reg[cmd.k];
        end
        if (cmd.nsum) begin
            num_reg <= NUMW'(nm_reg[0]) + NUMW'(nm_reg[1]) + NUMW'(nm_reg[2]);
        end
        if (cmd.nmul && cmd.k == 2'd0) begin
            sat_reg <= 1'b0;
        end else if (cmd.coord_ld) begin
            sat_reg <= sat_reg | dsat;
        end
        if (cmd.coord_ld) begin
            coord_reg[cmd.k] <= dcoord;
        end
        if (cmd.out_ld) begin
            out_data_reg <= {oz, oy, ox};
            out_user_reg <= {cmd.found & sat_reg, cmd.found};
        end
    end

    assign ox = cmd.found ? coord_reg[0] : '0;
    assign oy = cmd.found ? coord_reg[1] : '0;
    assign oz = cmd.found ? coord_reg[2] : '0;

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

    chvo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .det     (det_reg),
        .done    (ddone),
        .coord   (dcoord),
        .sat     (dsat)
    );

    assign sts.par      = par_reg;
    assign sts.det_zero = (det_reg == '0);
    assign sts.div_done = ddone;
endmodule
`default_nettype wire

### rtl/chvo_ctrl.sv
// Controller: plane loading, pair search sequence and result handshake.
`default_nettype none
`include "convex_hull_vertex_offset_defines.svh"
module chvo_ctrl import chvo_pkg::*; #(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire chvo_sts_t                     sts,
    output chvo_cmd_t                          cmd,
    output logic [$clog2(MAX_PLANES)-1:0]      waddr,
    output logic [$clog2(MAX_PLANES)-1:0]      raddr
);
    localparam int IW = $clog2(MAX_PLANES);
    localparam int CW = $clog2(MAX_PLANES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CHKI, S_RDI, S_LDI, S_XMUL_1I, S_XSUB_1I, S_SQ_I, S_CMP_I, S_DEC_I,
        S_CHKJ, S_RDJ, S_LDJ, S_XMUL_J1, S_XSUB_J1, S_SQ_J, S_CMP_J, S_DEC_J,
        S_XMUL_IJ, S_XSUB_IJ, S_TMUL, S_TSUM, S_TCHK, S_NMUL, S_NSUM, S_DIV, S_DIVW,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [1:0]    k_reg, k_next;
    logic          found_reg, found_next;
    logic          mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        found_next = found_reg;
        mv_next    = mv_reg && !m_tready;
        cmd        = '0;
        cmd.k      = k_reg;
        cmd.found  = found_reg;
        raddr      = i_reg[IW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (cnt_reg < CW'(MAX_PLANES)) begin
                        cmd.wr_plane = 1'b1;
                        cmd.ld_p1    = (cnt_reg == '0);
                        cnt_next     = cnt_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        i_next     = CW'(1);
                        found_next = 1'b0;
                        state_next = S_CHKI;
                    end
                end
            end
            S_CHKI:    state_next = (i_reg < cnt_reg) ? S_RDI : S_OUT;
            S_RDI:     state_next = S_LDI;
            S_LDI: begin
                cmd.ld_pi  = 1'b1;
                state_next = S_XMUL_1I;
            end
            S_XMUL_1I: begin
                cmd.xsel   = XS_1I;
                cmd.xmul   = 1'b1;
                state_next = S_XSUB_1I;
            end
            S_XSUB_1I: begin
                cmd.xsel   = XS_1I;
                cmd.xsub   = 1'b1;
                state_next = S_SQ_I;
            end
            S_SQ_I: begin
                cmd.sq     = 1'b1;
                state_next = S_CMP_I;
            end
            S_CMP_I: begin
                cmd.cmp    = 1'b1;
                state_next = S_DEC_I;
            end
            S_DEC_I: begin
                if (sts.par) begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CHKI;
                end else begin
                    j_next     = i_reg + CW'(1);
                    state_next = S_CHKJ;
                end
            end
            S_CHKJ: begin
                if (j_reg < cnt_reg) begin
                    state_next = S_RDJ;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CHKI;
                end
            end
            S_RDJ: begin
                raddr      = j_reg[IW-1:0];
                state_next = S_LDJ;
            end
            S_LDJ: begin
                cmd.ld_pj  = 1'b1;
                state_next = S_XMUL_J1;
            end
            S_XMUL_J1: begin
                cmd.xsel   = XS_J1;
                cmd.xmul   = 1'b1;
                state_next = S_XSUB_J1;
            end
            S_XSUB_J1: begin
                cmd.xsel   = XS_J1;
                cmd.xsub   = 1'b1;
                state_next = S_SQ_J;
            end
            S_SQ_J: begin
                cmd.sq     = 1'b1;
                state_next = S_CMP_J;
            end
            S_CMP_J: begin
                cmd.cmp    = 1'b1;
                state_next = S_DEC_J;
            end
            S_DEC_J: begin
                if (sts.par) begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_CHKJ;
                end else begin
                    state_next = S_XMUL_IJ;
                end
            end
            S_XMUL_IJ: begin
                cmd.xsel   = XS_IJ;
                cmd.xmul   = 1'b1;
                state_next = S_XSUB_IJ;
            end
            S_XSUB_IJ: begin
                cmd.xsel   = XS_IJ;
                cmd.xsub   = 1'b1;
                state_next = S_TMUL;
            end
            S_TMUL: begin
                cmd.tmul   = 1'b1;
                state_next = S_TSUM;
            end
            S_TSUM: begin
                cmd.tsum   = 1'b1;
                state_next = S_TCHK;
            end
            S_TCHK: begin
                if (sts.det_zero) begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_CHKJ;
                end else begin
                    k_next     = 2'd0;
                    state_next = S_NMUL;
                end
            end
            S_NMUL: begin
                cmd.nmul   = 1'b1;
                state_next = S_NSUM;
            end
            S_NSUM: begin
                cmd.nsum   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (sts.div_done) begin
                    cmd.coord_ld = 1'b1;
                    if (k_reg == 2'd2) begin
                        found_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_NMUL;
                    end
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    cmd.out_ld = 1'b1;
                    mv_next    = 1'b1;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            mv_reg    <= mv_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign waddr    = cnt_reg[IW-1:0];

    `CHVO_ASSERT_ALWAYS(a_cnt_max, aclk, aresetn, cnt_reg <= CW'(MAX_PLANES),
        "plane count exceeds the store depth")
    `CHVO_ASSERT_IMPL(a_j_order, aclk, aresetn, state_reg == S_RDJ,
        (j_reg > i_reg) && (j_reg < cnt_reg), "second plane index out of order")
    `CHVO_ASSERT_NEXT(a_out_clear, aclk, aresetn, cmd.out_ld, (cnt_reg == '0) && mv_reg,
        "result load did not restart the vertex")
    `CHVO_ASSERT_IMPL(a_found_path, aclk, aresetn, cmd.out_ld && found_reg,
        i_reg >= CW'(1) && j_reg > i_reg, "point reported without a valid pair")
endmodule
`default_nettype wire
